// ----- hw/rtl/bpa_pkg.sv -----
// Shared types and constants of the buddy page allocator.
// No dependencies.
package bpa_pkg;

	localparam int SIZE_W = 21;
	localparam int PAGE_W = 8;
	localparam int ORD_W  = 5;
	localparam int LVL_W  = 5;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	typedef struct packed {
		logic             too_large;
		logic [LVL_W-1:0] lvl;
	} size_dec_t;

endpackage

// ----- hw/rtl/bpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/bpa_size.sv -----
// Byte size to block level decoder of the buddy page allocator.
// Depends on bpa_pkg.
module bpa_size import bpa_pkg::*; #(
	parameter int PAGE_SHIFT = 12,
	parameter int POOL_ORDER = 20
) (
	input  logic [SIZE_W-1:0] size,
	output size_dec_t         dec
);

	localparam int L  = POOL_ORDER - PAGE_SHIFT;
	localparam int CW = ((POOL_ORDER + 1 > SIZE_W) ? POOL_ORDER + 1 : SIZE_W) + 1;

	logic [CW-1:0] size_ext;

	assign size_ext = CW'(size);

	always_comb begin
		dec.too_large = size_ext > (CW'(1) << POOL_ORDER);
		dec.lvl = '0;
		for (int j = 0; j < L; j++) begin
			if (size_ext > (CW'(1) << (PAGE_SHIFT + j))) begin
				dec.lvl = LVL_W'(j + 1);
			end
		end
	end

endmodule

// ----- hw/rtl/buddy_page_allocator.sv -----
// Buddy page allocator: request decode, tree walk sequencer, two RAMs.
// One word at a time; the time per word is set by the walk down (alloc only) and back up
// the node mask tree, one RAM read per level, plus any output stall.
// Reset: a sweep clears both RAMs, but marks the root block free; no word is taken
// until it ends. Depends on bpa_pkg, bpa_ram, bpa_size.
module buddy_page_allocator import bpa_pkg::*; #(
	parameter int PAGE_SHIFT = 12,
	parameter int POOL_ORDER = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // request_size[20:0], block_page[28:21], zeros
	input  logic [0:0]  s_tuser,  // mode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[1:0], granted_page[9:2], granted_order[14:10]
);

	localparam int L      = POOL_ORDER - PAGE_SHIFT;
	localparam int MW     = L + 1;
	localparam int NW     = L + 1;
	localparam int NPAGES = 1 << L;
	localparam int NDEPTH = 1 << NW;
	localparam int HW     = $clog2(L + 2);
	localparam int PW     = ((L > PAGE_W) ? L : PAGE_W) + 1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_ROOT, S_DESC, S_SPLIT_A, S_SPLIT_B, S_UP, S_UPW,
		S_HELD, S_MRG, S_MRGW, S_SET, S_DONE
	} state_t;

	state_t           state_q;
	logic [NW-1:0]    clr_q;
	logic [LVL_W-1:0] lvl_q;
	logic [LVL_W-1:0] k_q;
	logic [LVL_W-1:0] j_q;
	logic [NW-1:0]    cur_q;
	logic [NW-1:0]    top_q;
	logic [MW-1:0]    val_q;
	logic [L-1:0]     page_q;
	status_t          res_status_q;
	logic [PAGE_W-1:0] res_page_q;
	logic [ORD_W-1:0] res_order_q;
	logic             m_tvalid_q;
	logic [15:0]      m_tdata_q;

	logic             m_we;
	logic [NW-1:0]    m_waddr;
	logic [MW-1:0]    m_wdata;
	logic [NW-1:0]    m_raddr;
	logic [MW-1:0]    m_rdata;
	logic             h_we;
	logic [L-1:0]     h_waddr;
	logic [HW-1:0]    h_wdata;
	logic [L-1:0]     h_raddr;
	logic [HW-1:0]    h_rdata;

	size_dec_t        dec;
	logic [PW-1:0]    s_page_ext;
	logic             page_ok;
	logic             k_found;
	logic [LVL_W-1:0] k_sel;
	logic [NW-1:0]    desc_next;
	logic [MW-1:0]    split_mask;
	logic [NW-1:0]    cur_shl;
	logic [L-1:0]     page_f;
	logic             sib_free;
	logic [LVL_W-1:0] free_lvl;
	logic [NW-1:0]    free_node;

	bpa_size #(.PAGE_SHIFT(PAGE_SHIFT), .POOL_ORDER(POOL_ORDER)) u_size (
		.size (s_tdata[SIZE_W-1:0]),
		.dec  (dec)
	);

	bpa_ram #(.WIDTH(MW), .DEPTH(NDEPTH)) u_mask_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	bpa_ram #(.WIDTH(HW), .DEPTH(NPAGES)) u_held_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign s_page_ext = PW'(s_tdata[28:21]);
	assign page_ok    = s_page_ext < PW'(NPAGES);
	assign desc_next  = (cur_q << 1) | NW'(~|(m_rdata & (MW'(1) << k_q)));
	assign split_mask = (MW'(1) << j_q) - (MW'(1) << lvl_q);
	assign cur_shl    = cur_q << lvl_q;
	assign page_f     = cur_shl[L-1:0];
	assign sib_free   = |(m_rdata & (MW'(1) << lvl_q));
	assign free_lvl   = LVL_W'(h_rdata) - LVL_W'(1);
	assign free_node  = NW'({1'b1, page_q} >> free_lvl);

	always_comb begin
		k_found = 1'b0;
		k_sel   = '0;
		for (int j = L; j >= 0; j--) begin
			if (m_rdata[j] && (LVL_W'(j) >= lvl_q)) begin
				k_found = 1'b1;
				k_sel   = LVL_W'(j);
			end
		end
	end

	always_comb begin
		m_we    = 1'b0;
		m_waddr = cur_q;
		m_wdata = '0;
		m_raddr = cur_q ^ NW'(1);
		h_we    = 1'b0;
		h_waddr = page_q;
		h_wdata = '0;
		h_raddr = s_page_ext[L-1:0];
		case (state_q)
			S_CLR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
				m_wdata = (clr_q == NW'(1)) ? (MW'(1) << L) : '0;
				h_we    = 1'b1;
				h_waddr = clr_q[L-1:0];
			end
			S_IDLE: m_raddr = NW'(1);
			S_ROOT: m_raddr = NW'(2);
			S_DESC: m_raddr = desc_next << 1;
			S_SPLIT_A: begin
				m_we    = 1'b1;
				m_wdata = split_mask;
				if (j_q == lvl_q) begin
					h_we    = 1'b1;
					h_waddr = page_f;
					h_wdata = HW'(lvl_q) + HW'(1);
				end
			end
			S_SPLIT_B: begin
				m_we    = 1'b1;
				m_waddr = (cur_q << 1) | NW'(1);
				m_wdata = MW'(1) << (j_q - LVL_W'(1));
			end
			S_UPW: begin
				m_we    = 1'b1;
				m_waddr = cur_q >> 1;
				m_wdata = val_q | m_rdata;
			end
			S_HELD: h_we = (h_rdata != '0);
			S_MRGW: begin
				m_we    = sib_free;
				m_waddr = cur_q ^ NW'(1);
			end
			S_SET: begin
				m_we    = 1'b1;
				m_wdata = MW'(1) << lvl_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			res_status_q <= ST_OK;
			res_page_q   <= '0;
			res_order_q  <= '0;
			lvl_q        <= '0;
			k_q          <= '0;
			j_q          <= '0;
			cur_q        <= '0;
			top_q        <= '0;
			val_q        <= '0;
			page_q       <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(NDEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						res_status_q <= ST_OK;
						res_page_q   <= '0;
						res_order_q  <= '0;
						page_q       <= s_page_ext[L-1:0];
						lvl_q        <= dec.lvl;
						if (!s_tuser[0]) begin
							if (dec.too_large) begin
								res_status_q <= ST_NOSPACE;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_ROOT;
							end
						end else if (!page_ok) begin
							res_status_q <= ST_BADFREE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_HELD;
						end
					end
				end
				S_ROOT: begin
					cur_q <= NW'(1);
					top_q <= NW'(1);
					j_q   <= LVL_W'(L);
					k_q   <= k_sel;
					if (!k_found) begin
						res_status_q <= ST_NOSPACE;
						state_q      <= S_DONE;
					end else if (k_sel == LVL_W'(L)) begin
						state_q <= S_SPLIT_A;
					end else begin
						state_q <= S_DESC;
					end
				end
				S_DESC: begin
					cur_q <= desc_next;
					j_q   <= j_q - LVL_W'(1);
					if (j_q - LVL_W'(1) == k_q) begin
						top_q   <= desc_next;
						state_q <= S_SPLIT_A;
					end
				end
				S_SPLIT_A: begin
					if (j_q == lvl_q) begin
						res_page_q  <= PAGE_W'(page_f);
						res_order_q <= ORD_W'(lvl_q) + ORD_W'(PAGE_SHIFT);
						cur_q       <= top_q;
						val_q       <= (MW'(1) << k_q) - (MW'(1) << lvl_q);
						state_q     <= S_UP;
					end else begin
						state_q <= S_SPLIT_B;
					end
				end
				S_SPLIT_B: begin
					cur_q   <= cur_q << 1;
					j_q     <= j_q - LVL_W'(1);
					state_q <= S_SPLIT_A;
				end
				S_UP: begin
					state_q <= (cur_q == NW'(1)) ? S_DONE : S_UPW;
				end
				S_UPW: begin
					val_q   <= val_q | m_rdata;
					cur_q   <= cur_q >> 1;
					state_q <= S_UP;
				end
				S_HELD: begin
					if (h_rdata == '0) begin
						res_status_q <= ST_BADFREE;
						state_q      <= S_DONE;
					end else begin
						lvl_q   <= free_lvl;
						cur_q   <= free_node;
						state_q <= S_MRG;
					end
				end
				S_MRG: begin
					state_q <= (lvl_q == LVL_W'(L)) ? S_SET : S_MRGW;
				end
				S_MRGW: begin
					if (sib_free) begin
						cur_q   <= cur_q >> 1;
						lvl_q   <= lvl_q + LVL_W'(1);
						state_q <= S_MRG;
					end else begin
						state_q <= S_SET;
					end
				end
				S_SET: begin
					val_q   <= MW'(1) << lvl_q;
					state_q <= S_UP;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, res_order_q, res_page_q, res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3))
		else $error("status code out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[14:2] == '0))
		else $error("failed request carries a grant");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("word taken while busy");

endmodule
